// File: src/wps_pkg.sv
// Shared types, register indexes and reset timings for the LED strip serialiser.
`default_nettype none
package wps_pkg;

    // Tick period and nominal waveform timings in nanoseconds
    localparam int TICK_NS      = 20;
    localparam int ONE_HIGH_NS  = 900;
    localparam int ONE_LOW_NS   = 600;
    localparam int ZERO_HIGH_NS = 400;
    localparam int ZERO_LOW_NS  = 900;
    localparam int LATCH_NS     = 6000;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int PIXEL_W     = 24;
    localparam int BITS_W      = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam int TICK_COUNT_WIDTH_DEF = 16;

    // Reset values of the timing registers, in ticks
    localparam logic [CFG_W-1:0] ONE_HIGH_RST  = CFG_W'(ONE_HIGH_NS / TICK_NS);
    localparam logic [CFG_W-1:0] ONE_LOW_RST   = CFG_W'(ONE_LOW_NS / TICK_NS);
    localparam logic [CFG_W-1:0] ZERO_HIGH_RST = CFG_W'(ZERO_HIGH_NS / TICK_NS);
    localparam logic [CFG_W-1:0] ZERO_LOW_RST  = CFG_W'(ZERO_LOW_NS / TICK_NS);
    localparam logic [CFG_W-1:0] LATCH_GAP_RST =
        CFG_W'(((LATCH_NS / 1000) + 1) * 1000 / TICK_NS);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORDER = 3'd5;

    // Byte orders
    localparam logic ORDER_GRB = 1'b0;
    localparam logic ORDER_RGB = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] one_high;
        logic [CFG_W-1:0] one_low;
        logic [CFG_W-1:0] zero_high;
        logic [CFG_W-1:0] zero_low;
        logic [CFG_W-1:0] latch_gap;
        logic             color_order;
    } t_cfg;

    // One classified tick word: pixel already in send order
    typedef struct packed {
        logic               pixel;
        logic               show;
        logic               abort;
        logic [PIXEL_W-1:0] pixel_bits;
    } t_item;

endpackage
`default_nettype wire

// File: src/wps_front.sv
// Front stage: takes tick words, packs the pixel in send order, feeds the queue.
`default_nettype none
module wps_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_color_order,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [23:0]   i_data,   // red, green, blue
    input  wire logic [2:0]    i_user,   // pixel_valid, show_request, abort
    output logic               o_push,
    output wps_pkg::t_item     o_item,
    input  wire logic          i_queue_ready
);
    import wps_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Classify: pixel wins over show, byte order fixed here
    always_comb begin
        n_item.pixel = i_user[0];
        n_item.show  = i_user[1] & ~i_user[0];
        n_item.abort = i_user[2];
        if (i_color_order == ORDER_RGB) begin
            n_item.pixel_bits = {i_data[7:0], i_data[15:8], i_data[23:16]};
        end else begin
            n_item.pixel_bits = {i_data[15:8], i_data[7:0], i_data[23:16]};
        end
    end

    assign o_ready = ~r_valid | i_queue_ready;
    assign o_push  = r_valid & i_queue_ready;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// File: src/wps_queue.sv
// Short word queue between the front stage and the waveform engine.
`default_nettype none
module wps_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire wps_pkg::t_item i_item,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_valid,
    output wps_pkg::t_item      o_item
);
    import wps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// File: src/wps_back.sv
// Waveform engine: bit phases and latch gap, one queued tick word per cycle unless the output stalls.
`default_nettype none
module wps_back #(
    parameter int TICK_COUNT_WIDTH = wps_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire wps_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    input  wire wps_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_line_level,
    output logic                o_ready_res
);
    import wps_pkg::*;

    localparam int TCW = TICK_COUNT_WIDTH;
    localparam logic [31:0] TICK_MAX = 32'((64'd1 << TCW) - 64'd1);

    // Zero counts as one tick, overlong timings clip to the counter maximum
    function automatic logic [TCW-1:0] sat_ticks(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return TCW'(1);
        end else if (32'(v) > TICK_MAX) begin
            return TCW'(TICK_MAX);
        end else begin
            return TCW'(v);
        end
    endfunction

    logic [PIXEL_W-1:0] r_shift, n_shift;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic               r_high, n_high;
    logic [TCW-1:0]     r_cnt, n_cnt;
    logic               r_lat, n_lat;
    logic               r_out_valid;
    logic               r_line;
    logic               r_rdy;
    logic               line;
    logic               rdy;

    assign o_pop        = i_valid & (~r_out_valid | i_ready);
    assign o_valid      = r_out_valid;
    assign o_line_level = r_line;
    assign o_ready_res  = r_rdy;

    // Next state for one tick
    always_comb begin
        n_shift = r_shift;
        n_bits  = r_bits;
        n_high  = r_high;
        n_cnt   = r_cnt;
        n_lat   = r_lat;
        line    = 1'b0;
        rdy     = 1'b0;

        // Idle: start a pixel or a latch gap in this very tick
        if (r_cnt == '0) begin
            n_bits = '0;
            n_lat  = 1'b0;
            if (i_item.pixel) begin
                n_shift = i_item.pixel_bits;
                n_bits  = BITS_W'(PIXEL_W);
                n_high  = 1'b1;
                n_cnt   = sat_ticks(i_item.pixel_bits[PIXEL_W-1] ?
                                    i_cfg.one_high : i_cfg.zero_high);
                rdy     = 1'b1;
            end else if (i_item.show) begin
                n_lat  = 1'b1;
                n_high = 1'b0;
                n_cnt  = sat_ticks(i_cfg.latch_gap);
                rdy    = 1'b1;
            end
        end

        // Drive the line and count the phase down
        if (n_cnt != '0) begin
            line  = ~n_lat & n_high;
            n_cnt = n_cnt - 1'b1;
            if (n_cnt == '0) begin
                if (n_lat) begin
                    n_lat = 1'b0;
                end else if (n_high) begin
                    n_high = 1'b0;
                    n_cnt  = sat_ticks(n_shift[PIXEL_W-1] ?
                                       i_cfg.one_low : i_cfg.zero_low);
                end else begin
                    n_shift = {n_shift[PIXEL_W-2:0], 1'b0};
                    if (n_bits != '0) begin
                        n_bits = n_bits - 1'b1;
                    end
                    // abort only at a byte boundary with bytes still to go
                    if (n_bits != '0 && n_bits[2:0] == 3'd0 && i_item.abort) begin
                        n_bits = '0;
                    end
                    if (n_bits != '0) begin
                        n_high = 1'b1;
                        n_cnt  = sat_ticks(n_shift[PIXEL_W-1] ?
                                           i_cfg.one_high : i_cfg.zero_high);
                    end
                end
            end
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_bits      <= '0;
            r_high      <= 1'b0;
            r_cnt       <= '0;
            r_lat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_shift     <= n_shift;
                r_bits      <= n_bits;
                r_high      <= n_high;
                r_cnt       <= n_cnt;
                r_lat       <= n_lat;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_line <= line;
            r_rdy  <= rdy;
        end
    end

endmodule
`default_nettype wire

// File: src/ws2812_pixel_serializer.sv
// A tick word passes the front register, the queue and the output register of the engine.
// One tick word per cycle while the output is not stalled; the waveform engine steps once per word.
// A stalled output backs up through a four-word queue and the front register.
// Reset (synchronous, active low) loads the default timings and empties the queue.
`default_nettype none
module ws2812_pixel_serializer #(
    parameter int TICK_COUNT_WIDTH = wps_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [wps_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [23:0]                  s_axis_tdata,  // red, green, blue
    input  wire logic [2:0]                   s_axis_tuser,  // pixel_valid, show_request, abort
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // line_level, zero fill
    output logic                              m_axis_tuser   // ready_res
);
    import wps_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item queue_item;
    logic  front_push;
    logic  queue_ready;
    logic  queue_valid;
    logic  back_pop;
    logic  line_level;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high    <= ONE_HIGH_RST;
            r_cfg.one_low     <= ONE_LOW_RST;
            r_cfg.zero_high   <= ZERO_HIGH_RST;
            r_cfg.zero_low    <= ZERO_LOW_RST;
            r_cfg.latch_gap   <= LATCH_GAP_RST;
            r_cfg.color_order <= ORDER_GRB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ONE_HIGH:    r_cfg.one_high    <= i_cfg_data;
                REG_ONE_LOW:     r_cfg.one_low     <= i_cfg_data;
                REG_ZERO_HIGH:   r_cfg.zero_high   <= i_cfg_data;
                REG_ZERO_LOW:    r_cfg.zero_low    <= i_cfg_data;
                REG_LATCH_GAP:   r_cfg.latch_gap   <= i_cfg_data;
                REG_COLOR_ORDER: r_cfg.color_order <= i_cfg_data[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    wps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_color_order (r_cfg.color_order),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_user        (s_axis_tuser),
        .o_push        (front_push),
        .o_item        (front_item),
        .i_queue_ready (queue_ready)
    );

    wps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    wps_back #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (queue_valid),
        .i_item       (queue_item),
        .o_pop        (back_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_line_level (line_level),
        .o_ready_res  (m_axis_tuser)
    );

    assign m_axis_tdata = {7'b0, line_level};

endmodule
`default_nettype wire
